// ===== hdl/fbb_pkg.sv =====
package fbb_pkg;

    localparam int COORD_W     = 12;
    localparam int HALF_W      = 13;
    localparam int WIDTH_CFG_W = 13;
    localparam int GREEN_W     = 8;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 80;
    localparam int M_PAD_W     = M_TDATA_W - 4 * COORD_W - 2 * HALF_W;

    localparam logic [WIDTH_CFG_W-1:0] FRAME_WIDTH_RESET = 13'd640;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] x_min;
        logic [COORD_W-1:0] x_max;
        logic [COORD_W-1:0] y_min;
        logic [COORD_W-1:0] y_max;
        logic [HALF_W-1:0]  center_x_half;
        logic [HALF_W-1:0]  center_y_half;
    } box_t;

endpackage

// ===== hdl/fbb_box_track.sv =====
module fbb_box_track
    import fbb_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic                   pixel_hit,
    input  logic                   frame_last,
    input  logic [WIDTH_CFG_W-1:0] frame_width,
    output box_t                   box
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int CMPW = (XW + 1 > WIDTH_CFG_W + 1) ? XW + 1 : WIDTH_CFG_W + 1;

    logic [XW-1:0] column_count_reg, column_count_next;
    logic [YW-1:0] row_count_reg, row_count_next;
    logic          hit_seen_reg, hit_seen_next;
    logic [XW-1:0] left_edge_reg, left_edge_next;
    logic [XW-1:0] right_edge_reg, right_edge_next;
    logic [YW-1:0] top_edge_reg, top_edge_next;
    logic [YW-1:0] bottom_edge_reg, bottom_edge_next;

    logic [CMPW-1:0] col_inc;
    logic [CMPW-1:0] width_ext;
    logic [CMPW-1:0] limit;
    logic            row_wrap;
    logic            row_can_inc;

    logic [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi;

    assign col_inc     = CMPW'(column_count_reg) + CMPW'(1);
    assign width_ext   = CMPW'(frame_width);
    assign limit       = (width_ext > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : width_ext;
    assign row_wrap    = (col_inc >= limit);
    assign row_can_inc = ((YW + 1)'(row_count_reg) < (YW + 1)'(MAX_HEIGHT - 1));

    always_comb begin
        hit_seen_next    = hit_seen_reg;
        left_edge_next   = left_edge_reg;
        right_edge_next  = right_edge_reg;
        top_edge_next    = top_edge_reg;
        bottom_edge_next = bottom_edge_reg;
        if (pixel_hit) begin
            if (!hit_seen_reg) begin
                hit_seen_next    = 1'b1;
                left_edge_next   = column_count_reg;
                right_edge_next  = column_count_reg;
                top_edge_next    = row_count_reg;
                bottom_edge_next = row_count_reg;
            end else begin
                if (column_count_reg < left_edge_reg) begin
                    left_edge_next = column_count_reg;
                end
                if (column_count_reg > right_edge_reg) begin
                    right_edge_next = column_count_reg;
                end
                if (row_count_reg > bottom_edge_reg) begin
                    bottom_edge_next = row_count_reg;
                end
            end
        end
    end

    always_comb begin
        column_count_next = row_wrap ? '0 : col_inc[XW-1:0];
        row_count_next    = row_count_reg;
        if (row_wrap && row_can_inc) begin
            row_count_next = row_count_reg + YW'(1);
        end
    end

    // box including the current pixel
    assign x_lo = COORD_W'(left_edge_next);
    assign x_hi = COORD_W'(right_edge_next);
    assign y_lo = COORD_W'(top_edge_next);
    assign y_hi = COORD_W'(bottom_edge_next);

    always_comb begin
        box.found         = hit_seen_next;
        box.x_min         = x_lo;
        box.x_max         = x_hi;
        box.y_min         = y_lo;
        box.y_max         = y_hi;
        box.center_x_half = HALF_W'(x_lo) + HALF_W'(x_hi);
        box.center_y_half = HALF_W'(y_lo) + HALF_W'(y_hi);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            hit_seen_reg     <= 1'b0;
            left_edge_reg    <= '0;
            right_edge_reg   <= '0;
            top_edge_reg     <= '0;
            bottom_edge_reg  <= '0;
        end else if (step_en) begin
            if (frame_last) begin
                column_count_reg <= '0;
                row_count_reg    <= '0;
                hit_seen_reg     <= 1'b0;
                left_edge_reg    <= '0;
                right_edge_reg   <= '0;
                top_edge_reg     <= '0;
                bottom_edge_reg  <= '0;
            end else begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                hit_seen_reg     <= hit_seen_next;
                left_edge_reg    <= left_edge_next;
                right_edge_reg   <= right_edge_next;
                top_edge_reg     <= top_edge_next;
                bottom_edge_reg  <= bottom_edge_next;
            end
        end
    end

endmodule

// ===== hdl/foreground_bounding_box_top.sv =====
// Foreground bounding box over one raster frame.
// Input stream: one pixel word per accepted handshake, green level in
// s_axis_tdata[7:0], s_axis_tlast high on the final pixel of the frame.
// A pixel with nonzero green is foreground. The column counter wraps at
// frame_width (clamped to MAX_WIDTH), written through cfg_wr_en / cfg_wr_data;
// the user must write it only while the block is idle; the block does not check.
// Output stream: one word per frame, issued for the pixel marked tlast, with
// the box, its half-pixel centre and a found flag in m_axis_tuser; an empty
// frame gives found low, zero coordinates. Valid the cycle after tlast is taken.
// Throughput: one pixel per cycle; the counter and edge update plus the result
// register sit behind a single register stage.
// Stall: while a result waits in the output register and m_axis_tready is low,
// s_axis_tready is low; otherwise pixels flow in every cycle.
// Reset: aresetn low clears counters, edges and the output valid, and sets
// frame_width to 640.
module foreground_bounding_box_top
    import fbb_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [WIDTH_CFG_W-1:0] cfg_wr_data,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,  // green_level
    input  logic                   s_axis_tlast,  // frame_end

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // x_min, x_max, y_min, y_max, center_x_half, center_y_half, zero pad
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    output logic                   m_axis_tuser   // found
);

    logic [WIDTH_CFG_W-1:0] frame_width_reg;
    logic                   m_valid_reg;
    box_t                   box_reg;
    box_t                   box_now;
    logic                   s_accept;
    logic                   pixel_hit;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign pixel_hit     = (s_axis_tdata[GREEN_W-1:0] != '0);

    fbb_box_track #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (s_accept),
        .pixel_hit   (pixel_hit),
        .frame_last  (s_axis_tlast),
        .frame_width (frame_width_reg),
        .box         (box_now)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= FRAME_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            frame_width_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && s_axis_tlast) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_axis_tlast) begin
            box_reg <= box_now;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = box_reg.found;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, box_reg.center_y_half, box_reg.center_x_half,
                            box_reg.y_max, box_reg.y_min, box_reg.x_max, box_reg.x_min};

    a_result_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("result word without a frame end");

    a_empty_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("empty frame result not zero");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled with free output");

endmodule

// ===== tb/fbb_box_checker.sv =====
module fbb_box_checker
    import fbb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [WIDTH_CFG_W-1:0] cfg_wr_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                   s_axis_tlast,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                   m_axis_tuser,
    output int                     mismatches,
    output int                     boxes_waiting,
    output int                     frames_done,
    output int                     frames_hit
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS = 4096;
    localparam int MAX_ROWS = 4096;

    logic [WIDTH_CFG_W-1:0] width_reg;
    logic [COORD_W-1:0]     col;
    logic [COORD_W-1:0]     row;
    logic [COORD_W-1:0]     left;
    logic [COORD_W-1:0]     right;
    logic [COORD_W-1:0]     top;
    logic [COORD_W-1:0]     bottom;
    logic                   any_hit;
    box_t                   pending_boxes[$];

    initial begin
        mismatches    = 0;
        boxes_waiting = 0;
        frames_done   = 0;
        frames_hit    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 30) begin
            $display("%t mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d (frame %0d)",
                                      name, got, want, frames_done));
        end
    endtask

    task automatic clear_frame();
        col     = '0;
        row     = '0;
        left    = '0;
        right   = '0;
        top     = '0;
        bottom  = '0;
        any_hit = 1'b0;
    endtask

    task automatic take_pixel(input logic [GREEN_W-1:0] green, input logic last);
        int   limit;
        box_t box;
        limit = (width_reg > MAX_COLS) ? MAX_COLS : int'(width_reg);
        if (green != '0) begin
            if (!any_hit) begin
                any_hit = 1'b1;
                top     = row;
                bottom  = row;
                left    = col;
                right   = col;
            end else begin
                if (col < left) left = col;
                if (col > right) right = col;
                if (row > bottom) bottom = row;
            end
        end
        // width zero wraps every pixel, same as width one
        if (int'(col) + 1 >= limit) begin
            col = '0;
            if (int'(row) < MAX_ROWS - 1) row = row + 1'b1;
        end else begin
            col = col + 1'b1;
        end
        if (last) begin
            box = '0;
            if (any_hit) begin
                box.found         = 1'b1;
                box.x_min         = left;
                box.x_max         = right;
                box.y_min         = top;
                box.y_max         = bottom;
                box.center_x_half = {1'b0, left} + {1'b0, right};
                box.center_y_half = {1'b0, top} + {1'b0, bottom};
            end
            pending_boxes.push_back(box);
            clear_frame();
        end
    endtask

    always @(posedge aclk) begin
        box_t want;
        if (!aresetn) begin
            width_reg = FRAME_WIDTH_RESET;
            clear_frame();
            pending_boxes.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_boxes.size() == 0) begin
                    report_mismatch("box word with no frame pending");
                end else begin
                    want = pending_boxes.pop_front();
                    compare_field("found", int'(m_axis_tuser), int'(want.found));
                    compare_field("x_min", int'(m_axis_tdata[0*COORD_W +: COORD_W]),
                                  int'(want.x_min));
                    compare_field("x_max", int'(m_axis_tdata[1*COORD_W +: COORD_W]),
                                  int'(want.x_max));
                    compare_field("y_min", int'(m_axis_tdata[2*COORD_W +: COORD_W]),
                                  int'(want.y_min));
                    compare_field("y_max", int'(m_axis_tdata[3*COORD_W +: COORD_W]),
                                  int'(want.y_max));
                    compare_field("center_x_half",
                                  int'(m_axis_tdata[4*COORD_W +: HALF_W]),
                                  int'(want.center_x_half));
                    compare_field("center_y_half",
                                  int'(m_axis_tdata[4*COORD_W+HALF_W +: HALF_W]),
                                  int'(want.center_y_half));
                    frames_done++;
                    if (want.found) frames_hit++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_pixel(s_axis_tdata[GREEN_W-1:0], s_axis_tlast);
            end
            if (cfg_wr_en) begin
                width_reg = cfg_wr_data;
            end
        end
        boxes_waiting = pending_boxes.size();
    end

endmodule

// ===== tb/tb_foreground_bounding_box_top.sv =====
module tb_foreground_bounding_box_top;
    import fbb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1600;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [WIDTH_CFG_W-1:0] cfg_wr_data   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;

    int          mismatches;
    int          boxes_waiting;
    int          frames_done;
    int          frames_hit;
    int          burst_left   = 0;
    int          idle_cycles  = 0;
    int          random_items = 0;
    int          widths_used  = 0;
    logic [15:0] rx_phase     = '0;
    logic [1:0]  rx_mode      = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    foreground_bounding_box_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fbb_box_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .boxes_waiting (boxes_waiting),
        .frames_done   (frames_done),
        .frames_hit    (frames_hit)
    );

    // receiver backpressure, mode picked anew whenever rx_phase[7:0] is zero
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 1'b1;
        if (rx_phase[7:0] == 8'd0) rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: begin
                m_axis_tready <= 1'b1;
            end
            2'd1: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            2'd2: begin
                m_axis_tready <= (rx_phase[4:2] != 3'b101);
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL foreground_bounding_box_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [GREEN_W-1:0] green, input logic last);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= green;
        s_axis_tlast  <= last;
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
        burst_left--;
    endtask

    task automatic send_blank(input int count);
        repeat (count) send_pixel('0, 1'b0);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (boxes_waiting != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_width(input logic [WIDTH_CFG_W-1:0] width);
        hold_until_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= width;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        widths_used++;
    endtask

    initial begin
        logic [WIDTH_CFG_W-1:0] width;
        int                     len;
        int                     pct;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // empty frame, then a hit on the end word at the reset width
        send_blank(3);
        send_pixel('0, 1'b1);
        send_blank(5);
        send_pixel(8'h01, 1'b1);

        set_width(13'd4);
        send_blank(2);
        send_pixel(8'h80, 1'b0);
        send_blank(1);
        send_pixel(8'h55, 1'b0);
        send_blank(6);
        send_pixel(8'hAA, 1'b1);
        send_pixel(8'hFF, 1'b1);

        set_width(13'd0);
        send_blank(2);
        send_pixel(8'hFF, 1'b1);

        // one pixel per row
        set_width(13'd1);
        send_blank(10);
        send_pixel(8'h01, 1'b0);
        send_blank(4);
        send_pixel(8'h40, 1'b1);

        set_width(13'd4096);
        send_blank(20);
        send_pixel(8'h02, 1'b1);

        set_width(13'd8191);
        send_blank(30);
        send_pixel(8'h10, 1'b0);
        send_blank(1);
        send_pixel(8'h20, 1'b1);

        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: width = 13'd1;
                1: width = 13'd0;
                2: width = 13'($urandom_range(4097, 8191));
                3: width = 13'd4096;
                4, 5, 6: width = 13'($urandom_range(2, 8));
                default: width = 13'($urandom_range(9, 64));
            endcase
            set_width(width);
            repeat ($urandom_range(3, 12)) begin
                if (random_items < RANDOM_ITEMS) begin
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                      : $urandom_range(4, 60);
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 3;
                        2: pct = 25;
                        default: pct = 90;
                    endcase
                    for (int i = 0; i < len; i++) begin
                        send_pixel(($urandom_range(0, 99) < pct) ? 8'($urandom_range(1, 255))
                                                                 : 8'h00,
                                   i == len - 1);
                        random_items++;
                    end
                end
            end
        end

        hold_until_drained();
        repeat (8) @(posedge aclk);
        $display("checked %0d frame results, %0d with foreground, over %0d width settings",
                 frames_done, frames_hit, widths_used);
        $display("%0d random pixel words plus short directed frames at zero and clamped widths",
                 random_items);
        if (mismatches == 0 && boxes_waiting == 0) begin
            $display("PASS foreground_bounding_box_top");
        end else begin
            $display("FAIL foreground_bounding_box_top");
        end
        $finish;
    end

endmodule

// ===== foreground_bounding_box_top.f =====
hdl/fbb_pkg.sv
hdl/fbb_box_track.sv
hdl/foreground_bounding_box_top.sv
tb/fbb_box_checker.sv
tb/tb_foreground_bounding_box_top.sv
